// ----- src/gcm_pkg.sv -----
package gcm_pkg;

	// Widths fixed by the register map and the pixel format
	localparam int unsigned CFG_DIM_W  = 13;
	localparam int unsigned CFG_GRID_W = 9;
	localparam int unsigned CHAN_W     = 8;
	localparam int unsigned NUM_CHAN   = 3;
	localparam int unsigned SUM_W      = 32;
	localparam int unsigned AREA_W     = 2 * CFG_DIM_W;
	localparam int unsigned STEP_W     = $clog2(SUM_W);
	localparam int unsigned INDEX_W    = 16;
	localparam int unsigned ADDR_W     = 5;
	localparam int unsigned DATA_W     = 32;

	// Register indexes
	localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
	localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
	localparam logic [2:0] REG_GRID_COLUMNS = 3'd2;
	localparam logic [2:0] REG_CELL_WIDTH   = 3'd3;
	localparam logic [2:0] REG_CELL_HEIGHT  = 3'd4;

	// Register reset values
	localparam logic [CFG_DIM_W-1:0]  RST_IMAGE_WIDTH  = 13'd640;
	localparam logic [CFG_DIM_W-1:0]  RST_IMAGE_HEIGHT = 13'd480;
	localparam logic [CFG_GRID_W-1:0] RST_GRID_COLUMNS = 9'd40;
	localparam logic [CFG_DIM_W-1:0]  RST_CELL_WIDTH   = 13'd16;
	localparam logic [CFG_DIM_W-1:0]  RST_CELL_HEIGHT  = 13'd16;

	typedef struct packed {
		logic [CFG_DIM_W-1:0]  image_width;
		logic [CFG_DIM_W-1:0]  image_height;
		logic [CFG_GRID_W-1:0] grid_columns;
		logic [CFG_DIM_W-1:0]  cell_width;
		logic [CFG_DIM_W-1:0]  cell_height;
	} cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACC,
		ST_DIV,
		ST_LOAD
	} state_t;

	typedef struct packed {
		logic accept;
		logic acc;
		logic div_step;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic emit;
		logic div_last;
		logic out_free;
	} sts_t;

endpackage

// ----- src/gcm_ctrl.sv -----
module gcm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  gcm_pkg::sts_t sts,
	output gcm_pkg::cmd_t cmd
);
	import gcm_pkg::*;

	state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequence one pixel: accumulate, divide on cell end, hand to output register
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid) state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = sts.emit ? ST_DIV : ST_IDLE;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_d = ST_LOAD;
			end
			ST_LOAD: begin
				if (sts.out_free) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ----- src/gcm_datapath.sv -----
module gcm_datapath #(
	parameter int unsigned MAX_GRID_COLS = 256,
	parameter int unsigned MAX_IMAGE_DIM = 4096
) (
	input  logic          clk,
	input  logic          arst_n,
	input  gcm_pkg::cfg_t cfg,
	input  gcm_pkg::cmd_t cmd,
	output gcm_pkg::sts_t sts,
	input  logic [23:0]   pix_data,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [39:0]   out_data,
	output logic          out_last
);
	import gcm_pkg::*;

	localparam int unsigned DIM_W = $clog2(MAX_IMAGE_DIM);
	localparam int unsigned COL_W = (MAX_GRID_COLS > 1) ? $clog2(MAX_GRID_COLS) : 1;
	localparam int unsigned CMP_W = ((DIM_W > CFG_DIM_W) ? DIM_W : CFG_DIM_W) + 1;
	localparam int unsigned MEM_W = NUM_CHAN * SUM_W;
	localparam int unsigned PROD_W = INDEX_W;
	localparam logic [CMP_W-1:0] MAX_DIM = CMP_W'(MAX_IMAGE_DIM);
	localparam logic [COL_W-1:0] LAST_COL = COL_W'(MAX_GRID_COLS - 1);

	logic [MEM_W-1:0] mem [MAX_GRID_COLS];
	logic [MEM_W-1:0] rd_q;
	logic [NUM_CHAN*CHAN_W-1:0] pix_q;

	logic [DIM_W-1:0] pcol_q, prow_q, offx_q, offy_q, crow_q;
	logic [COL_W-1:0] ccol_q;

	logic [SUM_W-1:0]  quo_q [NUM_CHAN];
	logic [AREA_W-1:0] rem_q [NUM_CHAN];
	logic [AREA_W-1:0] area_q;
	logic [STEP_W-1:0] step_q;
	logic [INDEX_W-1:0] index_q;
	logic done_q;
	logic out_valid_q, out_last_q;
	logic [39:0] out_data_q;

	logic [CMP_W-1:0] w, h, cw, ch;
	logic last_x, last_y, cell_last_x, cell_last_y, first;
	logic [SUM_W-1:0] new_sum [NUM_CHAN];
	logic [MEM_W-1:0] new_word;
	logic [PROD_W-1:0] row_prod;

	// Clamp sizes: zero counts as one, image sizes saturate
	always_comb begin
		w  = (cfg.image_width == '0) ? CMP_W'(1) :
			((CMP_W'(cfg.image_width) > MAX_DIM) ? MAX_DIM : CMP_W'(cfg.image_width));
		h  = (cfg.image_height == '0) ? CMP_W'(1) :
			((CMP_W'(cfg.image_height) > MAX_DIM) ? MAX_DIM : CMP_W'(cfg.image_height));
		cw = (cfg.cell_width == '0) ? CMP_W'(1) : CMP_W'(cfg.cell_width);
		ch = (cfg.cell_height == '0) ? CMP_W'(1) : CMP_W'(cfg.cell_height);
	end

	// Position flags of the current pixel
	assign last_x      = (CMP_W'(pcol_q) + CMP_W'(1)) >= w;
	assign last_y      = (CMP_W'(prow_q) + CMP_W'(1)) >= h;
	assign cell_last_x = (CMP_W'(offx_q) + CMP_W'(1)) >= cw;
	assign cell_last_y = (CMP_W'(offy_q) + CMP_W'(1)) >= ch;
	assign first       = (offx_q == '0) && (offy_q == '0);

	// Start a cell with the pixel itself, else add to the stored sums
	always_comb begin
		for (int i = 0; i < NUM_CHAN; i++) begin
			new_sum[i] = (first ? '0 : rd_q[i*SUM_W +: SUM_W])
				+ SUM_W'(pix_q[i*CHAN_W +: CHAN_W]);
			new_word[i*SUM_W +: SUM_W] = new_sum[i];
		end
	end

	assign row_prod = PROD_W'(crow_q) * PROD_W'(cfg.grid_columns);

	// Sum memory: read on accept, write back in the accumulate cycle
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rd_q  <= mem[ccol_q];
			pix_q <= pix_data;
		end
		if (cmd.acc) begin
			mem[ccol_q] <= new_word;
		end
	end

	// Advance the raster and cell counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcol_q <= '0;
			prow_q <= '0;
			offx_q <= '0;
			offy_q <= '0;
			ccol_q <= '0;
			crow_q <= '0;
		end else if (cmd.acc) begin
			if (last_x) begin
				pcol_q <= '0;
				offx_q <= '0;
				ccol_q <= '0;
				if (last_y) begin
					prow_q <= '0;
					offy_q <= '0;
					crow_q <= '0;
				end else begin
					prow_q <= prow_q + 1'b1;
					if (cell_last_y) begin
						offy_q <= '0;
						crow_q <= crow_q + 1'b1;
					end else begin
						offy_q <= offy_q + 1'b1;
					end
				end
			end else begin
				pcol_q <= pcol_q + 1'b1;
				if (cell_last_x) begin
					offx_q <= '0;
					ccol_q <= (ccol_q == LAST_COL) ? '0 : ccol_q + 1'b1;
				end else begin
					offx_q <= offx_q + 1'b1;
				end
			end
		end
	end

	// Restoring divider: one quotient bit per cycle for all three channels
	always_ff @(posedge clk) begin
		if (cmd.acc) begin
			for (int i = 0; i < NUM_CHAN; i++) begin
				quo_q[i] <= new_sum[i];
				rem_q[i] <= '0;
			end
			area_q  <= AREA_W'(cw[CFG_DIM_W-1:0]) * AREA_W'(ch[CFG_DIM_W-1:0]);
			index_q <= INDEX_W'(row_prod + PROD_W'(ccol_q));
			done_q  <= last_x && last_y;
		end else if (cmd.div_step) begin
			for (int i = 0; i < NUM_CHAN; i++) begin
				logic [AREA_W:0] trial;
				trial = {rem_q[i], quo_q[i][SUM_W-1]} - {1'b0, area_q};
				if (!trial[AREA_W]) begin
					rem_q[i] <= trial[AREA_W-1:0];
					quo_q[i] <= {quo_q[i][SUM_W-2:0], 1'b1};
				end else begin
					rem_q[i] <= {rem_q[i][AREA_W-2:0], quo_q[i][SUM_W-1]};
					quo_q[i] <= {quo_q[i][SUM_W-2:0], 1'b0};
				end
			end
		end
	end

	// Count divider steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.acc) begin
			step_q <= '0;
		end else if (cmd.div_step) begin
			step_q <= step_q + 1'b1;
		end
	end

	// Output register: hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_data_q <= {quo_q[2][CHAN_W-1:0], quo_q[1][CHAN_W-1:0],
				quo_q[0][CHAN_W-1:0], index_q};
			out_last_q <= done_q;
		end
	end

	assign sts.emit     = (cell_last_x || last_x) && (cell_last_y || last_y);
	assign sts.div_last = (step_q == STEP_W'(SUM_W - 1));
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_last  = out_last_q;

endmodule

// ----- src/grid_cell_mean_color_unit.sv -----
// Grid cell mean color unit.
// Pixels of one frame enter in raster order on the slave stream (s_tdata:
// red, green, blue). The frame is cut into cells of cell_width by cell_height
// pixels; for the last pixel of each cell the master stream carries the cell
// index and the three channel sums divided by the full cell area, with
// m_tlast set on the final cell of the frame.
// Sizes are to be set through the APB port only while the stream is idle; the block does not enforce this.
// A pixel that closes no cell is accepted, then read-modify-written into the
// per-column sum memory. A pixel that closes a cell also passes the shared
// bit-serial divider, which yields 32 quotient bits for each channel, and the
// load of the output register. s_tready stays low until the pixel is through.
// When the receiver stalls, the result waits in the output register and the
// next pixels are still taken; a second result waits in the divider until
// the output register frees.
// Reset clears the raster counters, drops any pending result and restores the
// default register values; the sum memory is not cleared.
module grid_cell_mean_color_unit #(
	parameter int unsigned MAX_GRID_COLS = 256,
	parameter int unsigned MAX_IMAGE_DIM = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // cell_index[15:0], mean_red, mean_green, mean_blue
	output logic        m_tlast,   // frame_done
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [gcm_pkg::ADDR_W-1:0] paddr,
	input  logic [gcm_pkg::DATA_W-1:0] pwdata,
	output logic [gcm_pkg::DATA_W-1:0] prdata,
	output logic        pready
);
	import gcm_pkg::*;

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;
	logic wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[ADDR_W-1:2];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= RST_IMAGE_WIDTH;
			cfg_q.image_height <= RST_IMAGE_HEIGHT;
			cfg_q.grid_columns <= RST_GRID_COLUMNS;
			cfg_q.cell_width   <= RST_CELL_WIDTH;
			cfg_q.cell_height  <= RST_CELL_HEIGHT;
		end else if (wr_en) begin
			case (reg_idx)
				REG_IMAGE_WIDTH:  cfg_q.image_width  <= pwdata[CFG_DIM_W-1:0];
				REG_IMAGE_HEIGHT: cfg_q.image_height <= pwdata[CFG_DIM_W-1:0];
				REG_GRID_COLUMNS: cfg_q.grid_columns <= pwdata[CFG_GRID_W-1:0];
				REG_CELL_WIDTH:   cfg_q.cell_width   <= pwdata[CFG_DIM_W-1:0];
				REG_CELL_HEIGHT:  cfg_q.cell_height  <= pwdata[CFG_DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Register read back
	always_comb begin
		case (reg_idx)
			REG_IMAGE_WIDTH:  prdata = DATA_W'(cfg_q.image_width);
			REG_IMAGE_HEIGHT: prdata = DATA_W'(cfg_q.image_height);
			REG_GRID_COLUMNS: prdata = DATA_W'(cfg_q.grid_columns);
			REG_CELL_WIDTH:   prdata = DATA_W'(cfg_q.cell_width);
			REG_CELL_HEIGHT:  prdata = DATA_W'(cfg_q.cell_height);
			default:          prdata = '0;
		endcase
	end

	gcm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	gcm_datapath #(
		.MAX_GRID_COLS (MAX_GRID_COLS),
		.MAX_IMAGE_DIM (MAX_IMAGE_DIM)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (cmd),
		.sts       (sts),
		.pix_data  (s_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_last  (m_tlast)
	);

endmodule

// ----- tb/gcm_checker.sv -----
module gcm_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	input  logic                       s_tready,
	input  logic [23:0]                s_tdata,   // red[7:0], green[15:8], blue[23:16]
	input  logic                       m_tvalid,
	input  logic                       m_tready,
	input  logic [39:0]                m_tdata,   // cell_index, mean_red, mean_green, mean_blue
	input  logic                       m_tlast,   // frame_done
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [gcm_pkg::ADDR_W-1:0] paddr,
	input  logic [gcm_pkg::DATA_W-1:0] pwdata,
	input  logic                       pready,
	output int                         failures,
	output int                         pending
);
	import gcm_pkg::*;

	localparam int unsigned GRID_COLS = 256;
	localparam int unsigned IMAGE_DIM = 4096;

	typedef struct {
		logic [INDEX_W-1:0] cell_index;
		logic [CHAN_W-1:0]  mean_red;
		logic [CHAN_W-1:0]  mean_green;
		logic [CHAN_W-1:0]  mean_blue;
		logic               frame_done;
	} cell_mean_t;

	cell_mean_t cell_means_due[$];

	logic [CFG_DIM_W-1:0]  image_w, image_h, cell_w, cell_h;
	logic [CFG_GRID_W-1:0] grid_cols;
	logic [SUM_W-1:0]      red_acc [GRID_COLS];
	logic [SUM_W-1:0]      green_acc [GRID_COLS];
	logic [SUM_W-1:0]      blue_acc [GRID_COLS];
	int unsigned           x_pos, y_pos, x_in_cell, y_in_cell, cell_col, cell_row;

	// Zero counts as 1, anything above the cap is clipped to it
	function automatic int unsigned fit_size(int unsigned v, int unsigned cap);
		if (v == 0)
			return 1;
		if (v > cap)
			return cap;
		return v;
	endfunction

	// Accumulate one pixel and queue the cell mean it closes, if any
	task automatic accumulate_pixel(input logic [23:0] px);
		int unsigned w, h, cw, ch, col, area;
		logic        edge_x, edge_y, end_x, end_y;
		cell_mean_t  cm;
		w = fit_size(32'(image_w), IMAGE_DIM);
		h = fit_size(32'(image_h), IMAGE_DIM);
		cw = fit_size(32'(cell_w), 32'h1FFF);
		ch = fit_size(32'(cell_h), 32'h1FFF);
		col = cell_col % GRID_COLS;
		edge_x = (x_pos + 1 >= w);
		edge_y = (y_pos + 1 >= h);
		end_x = (x_in_cell + 1 >= cw);
		end_y = (y_in_cell + 1 >= ch);
		if (x_in_cell == 0 && y_in_cell == 0) begin
			red_acc[col] = SUM_W'(px[7:0]);
			green_acc[col] = SUM_W'(px[15:8]);
			blue_acc[col] = SUM_W'(px[23:16]);
		end else begin
			red_acc[col] = red_acc[col] + SUM_W'(px[7:0]);
			green_acc[col] = green_acc[col] + SUM_W'(px[15:8]);
			blue_acc[col] = blue_acc[col] + SUM_W'(px[23:16]);
		end
		if ((end_x || edge_x) && (end_y || edge_y)) begin
			area = cw * ch;
			cm.cell_index = INDEX_W'(cell_row * 32'(grid_cols) + col);
			cm.mean_red = CHAN_W'(red_acc[col] / area);
			cm.mean_green = CHAN_W'(green_acc[col] / area);
			cm.mean_blue = CHAN_W'(blue_acc[col] / area);
			cm.frame_done = edge_x && edge_y;
			cell_means_due.insert(cell_means_due.size(), cm);
		end
		// Advance the raster position
		if (edge_x) begin
			x_pos = 0;
			x_in_cell = 0;
			cell_col = 0;
			if (edge_y) begin
				y_pos = 0;
				y_in_cell = 0;
				cell_row = 0;
			end else begin
				y_pos++;
				if (end_y) begin
					y_in_cell = 0;
					cell_row++;
				end else begin
					y_in_cell++;
				end
			end
		end else begin
			x_pos++;
			if (end_x) begin
				x_in_cell = 0;
				cell_col = (col + 1) % GRID_COLS;
			end else begin
				x_in_cell++;
			end
		end
	endtask

	// Compare one cell result with the oldest queued mean
	task automatic check_cell_mean();
		cell_mean_t cm;
		if (cell_means_due.size() == 0) begin
			$error("cell result %h with no pixel behind it", m_tdata);
			failures++;
		end else begin
			cm = cell_means_due.pop_front();
			if (m_tdata[15:0] !== cm.cell_index) begin
				$error("cell_index expected %0d actual %0d", cm.cell_index, m_tdata[15:0]);
				failures++;
			end
			if (m_tdata[23:16] !== cm.mean_red) begin
				$error("mean_red expected %0d actual %0d", cm.mean_red, m_tdata[23:16]);
				failures++;
			end
			if (m_tdata[31:24] !== cm.mean_green) begin
				$error("mean_green expected %0d actual %0d", cm.mean_green, m_tdata[31:24]);
				failures++;
			end
			if (m_tdata[39:32] !== cm.mean_blue) begin
				$error("mean_blue expected %0d actual %0d", cm.mean_blue, m_tdata[39:32]);
				failures++;
			end
			if (m_tlast !== cm.frame_done) begin
				$error("frame_done expected %0d actual %0d", cm.frame_done, m_tlast);
				failures++;
			end
		end
	endtask

	// Track register writes, pixels and cell results
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_w = RST_IMAGE_WIDTH;
			image_h = RST_IMAGE_HEIGHT;
			grid_cols = RST_GRID_COLUMNS;
			cell_w = RST_CELL_WIDTH;
			cell_h = RST_CELL_HEIGHT;
			x_pos = 0;
			y_pos = 0;
			x_in_cell = 0;
			y_in_cell = 0;
			cell_col = 0;
			cell_row = 0;
			cell_means_due.delete();
			failures = 0;
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_IMAGE_WIDTH: image_w = pwdata[CFG_DIM_W-1:0];
					REG_IMAGE_HEIGHT: image_h = pwdata[CFG_DIM_W-1:0];
					REG_GRID_COLUMNS: grid_cols = pwdata[CFG_GRID_W-1:0];
					REG_CELL_WIDTH: cell_w = pwdata[CFG_DIM_W-1:0];
					REG_CELL_HEIGHT: cell_h = pwdata[CFG_DIM_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				accumulate_pixel(s_tdata);
			if (m_tvalid && m_tready)
				check_cell_mean();
			pending = cell_means_due.size();
		end
	end

endmodule

// ----- tb/tb_grid_cell_mean_color_unit.sv -----
module tb_grid_cell_mean_color_unit;
	import gcm_pkg::*;

	localparam int DRAIN_CYCLES = 40;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [23:0]       s_tdata = '0;   // red[7:0], green[15:8], blue[23:16]
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [39:0]       m_tdata;        // cell_index, mean_red, mean_green, mean_blue
	logic              m_tlast;        // frame_done
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	int                failures;
	int                pending;
	int                burst_left = 0;
	int                random_pixels = 0;
	int                stall_mode = 0;
	int                stall_left = 0;

	always #5 clk = ~clk;

	grid_cell_mean_color_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	gcm_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready), .failures(failures), .pending(pending)
	);

	// Stall the result side, switching between free, random and sparse patterns
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_left = $urandom_range(64, 512);
		end
		stall_left--;
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			default: m_tready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// Write one register through a setup and an access phase
	task automatic write_reg(input logic [2:0] index, input int unsigned value);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = {index, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// Hold until every cell result is out and the divider has drained
	task automatic wait_idle();
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Send one pixel request, in bursts with random gaps between them
	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_tvalid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tvalid = 1'b1;
		s_tdata = {b, g, r};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [7:0] pick_channel();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_pixels(input int count);
		for (int i = 0; i < count; i++)
			send_pixel(pick_channel(), pick_channel(), pick_channel());
		s_tvalid = 1'b0;
	endtask

	task automatic set_grid(input int unsigned w, input int unsigned h, input int unsigned gc,
			input int unsigned cw, input int unsigned ch);
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		write_reg(REG_GRID_COLUMNS, gc);
		write_reg(REG_CELL_WIDTH, cw);
		write_reg(REG_CELL_HEIGHT, ch);
	endtask

	// Configure, send one whole frame, then drain
	task automatic run_frame(input int unsigned w, input int unsigned h, input int unsigned gc,
			input int unsigned cw, input int unsigned ch);
		int unsigned fw, fh;
		fw = (w == 0) ? 1 : (w > 4096) ? 4096 : w;
		fh = (h == 0) ? 1 : (h > 4096) ? 4096 : h;
		set_grid(w, h, gc, cw, ch);
		send_pixels(fw * fh);
		wait_idle();
	endtask

	initial begin
		int unsigned w, h, cw, ch, gc;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: clipped cells, all-white then zeros
		set_grid(3, 2, 2, 2, 2);
		for (int i = 0; i < 3; i++)
			send_pixel(8'hFF, 8'hFF, 8'hFF);
		for (int i = 0; i < 3; i++)
			send_pixel(8'h00, 8'h00, 8'h00);
		s_tvalid = 1'b0;
		wait_idle();
		// Zero sizes act as 1: every pixel is a whole frame
		set_grid(0, 0, 0, 0, 0);
		send_pixels(2);
		wait_idle();
		// Largest cells, far bigger than the image
		run_frame(2, 2, 1, 13'h1FFF, 13'h1FFF);
		// Grid column change between two cell rows of one frame
		set_grid(4, 4, 2, 2, 2);
		send_pixels(8);
		wait_idle();
		write_reg(REG_GRID_COLUMNS, 9'h1FF);
		send_pixels(8);
		wait_idle();

		// More cell columns than sum entries: distant columns share sums
		run_frame(260, 1, 260, 1, 1);

		// Random frames with small sizes
		while (random_pixels < 350) begin
			w = $urandom_range(1, 20);
			h = $urandom_range(1, 10);
			cw = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 24) : $urandom_range(1, 6);
			ch = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 12) : $urandom_range(1, 4);
			gc = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511)
				: (w + ((cw == 0) ? 1 : cw) - 1) / ((cw == 0) ? 1 : cw);
			if ($urandom_range(0, 9) == 0)
				w = 0;
			run_frame(w, h, gc, cw, ch);
			random_pixels += ((w == 0) ? 1 : w) * h;
		end

		if (failures == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#10000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
